/* design/bc3_pkg.sv */
// Shared widths and beat structures for the BC3 / scaled-YCoCg block decoder.
// No dependencies; every design module imports this package.
package bc3_pkg;

    localparam int BLK_W     = 64;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 4;
    localparam int NUM_PIX   = 16;
    localparam int AIDX_W    = 3;
    localparam int CIDX_W    = 2;
    localparam int C565_W    = 16;
    localparam int AIDX_LSB  = 16;
    localparam int CIDX_LSB  = 32;

    // Per-pixel selection taken from the held block.
    typedef struct packed {
        logic [CH_W-1:0]   e0;
        logic [CH_W-1:0]   e1;
        logic [AIDX_W-1:0] ai;
        logic [C565_W-1:0] c0;
        logic [C565_W-1:0] c1;
        logic [CIDX_W-1:0] ci;
    } blk_sel_t;

    // Position tag that travels with every pixel beat.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } pix_tag_t;

    // One decoded pixel.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } rgba_t;

endpackage

/* design/bc3_ycocg_block_decoder.sv */
// BC3 block decoder with optional scaled-YCoCg conversion: 16 pixels per block, one per cycle
// while the output is not stalled. The first pixel of an accepted block passes through the
// sequencer, both palette stages, the conversion stage and the output register;
// the next block is taken in the cycle its predecessor's last pixel leaves the sequencer.
// Reset clears all valid bits and the sequencer and sets ycocg_enable to 1.
module bc3_ycocg_block_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bc3_pkg::BLK_W-1:0] alpha_block,
    input  logic [bc3_pkg::BLK_W-1:0] color_block,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bc3_pkg::PIX_W-1:0] pixel_index,
    output logic [bc3_pkg::CH_W-1:0]  red,
    output logic [bc3_pkg::CH_W-1:0]  green,
    output logic [bc3_pkg::CH_W-1:0]  blue,
    output logic [bc3_pkg::CH_W-1:0]  alpha,
    output logic                      last_pixel
);
    import bc3_pkg::*;

    logic      ycocg_enable_reg;
    logic      adv;
    logic      sel_valid;
    blk_sel_t  sel;
    pix_tag_t  sel_tag;
    logic      px_valid;
    rgba_t     px;
    pix_tag_t  px_tag;
    rgba_t     out_px;
    pix_tag_t  out_tag;

    // Configuration register; a write beat is always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ycocg_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ycocg_enable_reg <= cfg_data;
        end
    end

    // The whole pipeline moves whenever the output register is empty or being taken.
    assign adv = !out_valid || !out_stall;

    bc3_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .alpha_block (alpha_block),
        .color_block (color_block),
        .sel_valid   (sel_valid),
        .sel         (sel),
        .sel_tag     (sel_tag)
    );

    bc3_pal u_pal (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sel_valid (sel_valid),
        .sel       (sel),
        .sel_tag   (sel_tag),
        .px_valid  (px_valid),
        .px        (px),
        .px_tag    (px_tag)
    );

    bc3_ycc u_ycc (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .ycocg_enable (ycocg_enable_reg),
        .px_valid     (px_valid),
        .px           (px),
        .px_tag       (px_tag),
        .out_valid    (out_valid),
        .out_px       (out_px),
        .out_tag      (out_tag)
    );

    // Result ports.
    assign pixel_index = out_tag.pix;
    assign last_pixel  = out_tag.last;
    assign red         = out_px.red;
    assign green       = out_px.green;
    assign blue        = out_px.blue;
    assign alpha       = out_px.alpha;

endmodule

/* design/bc3_seq.sv */
// Block holding register and pixel sequencer: issues one pixel selection per cycle
// while adv is high. Depends on bc3_pkg.
module bc3_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [bc3_pkg::BLK_W-1:0] alpha_block,
    input  logic [bc3_pkg::BLK_W-1:0] color_block,
    output logic                    sel_valid,
    output bc3_pkg::blk_sel_t       sel,
    output bc3_pkg::pix_tag_t       sel_tag
);
    import bc3_pkg::*;

    logic             busy_reg, busy_next;
    logic [PIX_W-1:0] cnt_reg, cnt_next;
    logic [BLK_W-1:0] ablk_reg;
    logic [BLK_W-1:0] cblk_reg;
    logic             issue;
    logic             done;
    logic             accept;

    // A new block may load in the same cycle as the last pixel of the current one leaves.
    assign issue    = busy_reg && adv;
    assign done     = issue && (cnt_reg == PIX_W'(NUM_PIX - 1));
    assign in_stall = busy_reg && !done;
    assign accept   = in_valid && !in_stall;

    // Sequencer next state.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (issue)
        begin
            cnt_next = cnt_reg + PIX_W'(1);
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Block payload is captured on the accepted beat only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ablk_reg <= alpha_block;
            cblk_reg <= color_block;
        end
    end

    // Pick out the endpoints and this pixel's indices.
    always_comb
    begin
        sel.e0 = ablk_reg[CH_W-1:0];
        sel.e1 = ablk_reg[2*CH_W-1:CH_W];
        sel.ai = ablk_reg[AIDX_LSB + AIDX_W*int'(cnt_reg) +: AIDX_W];
        sel.c0 = cblk_reg[C565_W-1:0];
        sel.c1 = cblk_reg[2*C565_W-1:C565_W];
        sel.ci = cblk_reg[CIDX_LSB + CIDX_W*int'(cnt_reg) +: CIDX_W];
        sel_tag.pix  = cnt_reg;
        sel_tag.last = (cnt_reg == PIX_W'(NUM_PIX - 1));
    end

    assign sel_valid = busy_reg;

endmodule

/* design/bc3_pal.sv */
// Palette and alpha decode: stage one forms the interpolation numerators,
// stage two divides by the small constants. Depends on bc3_pkg.
module bc3_pal (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              sel_valid,
    input  bc3_pkg::blk_sel_t sel,
    input  bc3_pkg::pix_tag_t sel_tag,
    output logic              px_valid,
    output bc3_pkg::rgba_t    px,
    output bc3_pkg::pix_tag_t px_tag
);
    import bc3_pkg::*;

    localparam int NUM_W  = 11;
    localparam int PROD_W = 22;
    localparam int NCH    = 4;

    typedef enum logic [2:0] {DIV_NONE, DIV_2, DIV_3, DIV_5, DIV_7} div_kind_t;

    // Division of a numerator by a constant through a scaled reciprocal.
    // Each reciprocal is exact over the numerator range that reaches it.
    function automatic logic [CH_W-1:0] div_const(input logic [NUM_W-1:0] num,
                                                  input div_kind_t kind);
        logic [PROD_W-1:0] p3;
        logic [PROD_W-1:0] p5;
        logic [PROD_W-1:0] p7;
        logic [CH_W-1:0]   q;
        p3 = PROD_W'(num) * PROD_W'(683);
        p5 = PROD_W'(num) * PROD_W'(1639);
        p7 = PROD_W'(num) * PROD_W'(2341);
        case (kind)
            DIV_NONE: q = num[CH_W-1:0];
            DIV_2:    q = num[CH_W:1];
            DIV_3:    q = p3[18:11];
            DIV_5:    q = p5[20:13];
            DIV_7:    q = p7[21:14];
            default:  q = num[CH_W-1:0];
        endcase
        return q;
    endfunction

    // RGB565 to 8-bit channels by bit replication, packed red, green, blue.
    function automatic logic [3*CH_W-1:0] expand565(input logic [C565_W-1:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

    logic [3*CH_W-1:0] p0_all, p1_all;
    logic [CH_W-1:0]   p0 [3];
    logic [CH_W-1:0]   p1 [3];
    logic              four;
    logic [NUM_W-1:0]  num_next  [NCH];
    div_kind_t         kind_next [NCH];
    logic [3:0]        w0, w1;
    logic [11:0]       a_sum;

    logic              v1_reg;
    pix_tag_t          tag1_reg;
    logic [NUM_W-1:0]  num_reg  [NCH];
    div_kind_t         kind_reg [NCH];

    logic              v2_reg;
    pix_tag_t          tag2_reg;
    rgba_t             px_reg, px_next;

    assign p0_all = expand565(sel.c0);
    assign p1_all = expand565(sel.c1);
    assign four   = sel.c0 > sel.c1;

    // Colour numerators, channel 0 red, 1 green, 2 blue, then the alpha numerator in channel 3.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p0[k] = p0_all[(2-k)*CH_W +: CH_W];
            p1[k] = p1_all[(2-k)*CH_W +: CH_W];
            case (sel.ci)
                2'd0:
                begin
                    num_next[k]  = NUM_W'(p0[k]);
                    kind_next[k] = DIV_NONE;
                end
                2'd1:
                begin
                    num_next[k]  = NUM_W'(p1[k]);
                    kind_next[k] = DIV_NONE;
                end
                2'd2:
                begin
                    if (four)
                    begin
                        num_next[k]  = (NUM_W'(p0[k]) << 1) + NUM_W'(p1[k]);
                        kind_next[k] = DIV_3;
                    end
                    else
                    begin
                        num_next[k]  = NUM_W'(p0[k]) + NUM_W'(p1[k]);
                        kind_next[k] = DIV_2;
                    end
                end
                default:
                begin
                    if (four)
                    begin
                        num_next[k]  = (NUM_W'(p1[k]) << 1) + NUM_W'(p0[k]);
                        kind_next[k] = DIV_3;
                    end
                    else
                    begin
                        num_next[k]  = '0;
                        kind_next[k] = DIV_NONE;
                    end
                end
            endcase
        end

        // Alpha: eight-step mode when e0 > e1, else six-step with fixed 0 and 255.
        w0    = '0;
        w1    = 4'(sel.ai) - 4'd1;
        a_sum = '0;
        if (sel.ai == 3'd0)
        begin
            num_next[3]  = NUM_W'(sel.e0);
            kind_next[3] = DIV_NONE;
        end
        else if (sel.ai == 3'd1)
        begin
            num_next[3]  = NUM_W'(sel.e1);
            kind_next[3] = DIV_NONE;
        end
        else if (sel.e0 > sel.e1)
        begin
            w0           = 4'd8 - 4'(sel.ai);
            a_sum        = 12'(w0) * 12'(sel.e0) + 12'(w1) * 12'(sel.e1);
            num_next[3]  = a_sum[NUM_W-1:0];
            kind_next[3] = DIV_7;
        end
        else if (sel.ai == 3'd6)
        begin
            num_next[3]  = '0;
            kind_next[3] = DIV_NONE;
        end
        else if (sel.ai == 3'd7)
        begin
            num_next[3]  = NUM_W'(255);
            kind_next[3] = DIV_NONE;
        end
        else
        begin
            w0           = 4'd6 - 4'(sel.ai);
            a_sum        = 12'(w0) * 12'(sel.e0) + 12'(w1) * 12'(sel.e1);
            num_next[3]  = a_sum[NUM_W-1:0];
            kind_next[3] = DIV_5;
        end
    end

    // Stage one and stage two valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= sel_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag1_reg <= sel_tag;
            for (int k = 0; k < NCH; k++)
            begin
                num_reg[k]  <= num_next[k];
                kind_reg[k] <= kind_next[k];
            end
        end
    end

    // Stage two: constant divisions.
    always_comb
    begin
        px_next.red   = div_const(num_reg[0], kind_reg[0]);
        px_next.green = div_const(num_reg[1], kind_reg[1]);
        px_next.blue  = div_const(num_reg[2], kind_reg[2]);
        px_next.alpha = div_const(num_reg[3], kind_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag2_reg <= tag1_reg;
            px_reg   <= px_next;
        end
    end

    assign px_valid = v2_reg;
    assign px       = px_reg;
    assign px_tag   = tag2_reg;

endmodule

/* design/bc3_ycc.sv */
// Scaled-YCoCg to RGB conversion (reciprocal multiply stage, then sum and clamp)
// and the output register. Depends on bc3_pkg.
module bc3_ycc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              ycocg_enable,
    input  logic              px_valid,
    input  bc3_pkg::rgba_t    px,
    input  bc3_pkg::pix_tag_t px_tag,
    output logic              out_valid,
    output bc3_pkg::rgba_t    out_px,
    output bc3_pkg::pix_tag_t out_tag
);
    import bc3_pkg::*;

    localparam int RCP_W  = 17;
    localparam int PROD_W = 25;
    localparam int Q_W    = 9;
    localparam int SUM_W  = 11;

    // Reciprocal ceil(65536 / s) for scale s = code + 1; exact for magnitudes up to 128.
    function automatic logic [RCP_W-1:0] recip_lut(input logic [4:0] code);
        logic [RCP_W-1:0] r;
        case (code)
            5'd0:  r = RCP_W'(65536);
            5'd1:  r = RCP_W'(32768);
            5'd2:  r = RCP_W'(21846);
            5'd3:  r = RCP_W'(16384);
            5'd4:  r = RCP_W'(13108);
            5'd5:  r = RCP_W'(10923);
            5'd6:  r = RCP_W'(9363);
            5'd7:  r = RCP_W'(8192);
            5'd8:  r = RCP_W'(7282);
            5'd9:  r = RCP_W'(6554);
            5'd10: r = RCP_W'(5958);
            5'd11: r = RCP_W'(5462);
            5'd12: r = RCP_W'(5042);
            5'd13: r = RCP_W'(4682);
            5'd14: r = RCP_W'(4370);
            5'd15: r = RCP_W'(4096);
            5'd16: r = RCP_W'(3856);
            5'd17: r = RCP_W'(3641);
            5'd18: r = RCP_W'(3450);
            5'd19: r = RCP_W'(3277);
            5'd20: r = RCP_W'(3121);
            5'd21: r = RCP_W'(2979);
            5'd22: r = RCP_W'(2850);
            5'd23: r = RCP_W'(2731);
            5'd24: r = RCP_W'(2622);
            5'd25: r = RCP_W'(2521);
            5'd26: r = RCP_W'(2428);
            5'd27: r = RCP_W'(2341);
            5'd28: r = RCP_W'(2260);
            5'd29: r = RCP_W'(2185);
            5'd30: r = RCP_W'(2115);
            default: r = RCP_W'(2048);
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] v);
        logic [CH_W-1:0] c;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > SUM_W'(255))
        begin
            c = '1;
        end
        else
        begin
            c = v[CH_W-1:0];
        end
        return c;
    endfunction

    logic [CH_W-1:0]   mag_g, mag_r;
    logic [RCP_W-1:0]  rcp;

    logic              v3_reg;
    pix_tag_t          tag3_reg;
    rgba_t             pass_reg;
    logic [PROD_W-1:0] prod_g_reg, prod_r_reg;
    logic              neg_g_reg, neg_r_reg;

    logic [Q_W-1:0]           q_g, q_r;
    logic signed [SUM_W-1:0]  cg, co, y;
    logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
    rgba_t                    conv, out_next;

    logic              out_valid_reg;
    pix_tag_t          out_tag_reg;
    rgba_t             out_px_reg;

    // Stage three: magnitudes of chroma offsets from 128, times the scale reciprocal.
    assign mag_g = px.green[7] ? {1'b0, px.green[6:0]} : CH_W'(9'd128 - 9'(px.green));
    assign mag_r = px.red[7]   ? {1'b0, px.red[6:0]}   : CH_W'(9'd128 - 9'(px.red));
    assign rcp   = recip_lut(px.blue[7:3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag3_reg   <= px_tag;
            pass_reg   <= px;
            prod_g_reg <= PROD_W'(mag_g) * PROD_W'(rcp);
            prod_r_reg <= PROD_W'(mag_r) * PROD_W'(rcp);
            neg_g_reg  <= !px.green[7];
            neg_r_reg  <= !px.red[7];
        end
    end

    // Stage four: signed quotients, recombination and clamping, or the pass-through pixel.
    always_comb
    begin
        q_g   = prod_g_reg[PROD_W-1:16];
        q_r   = prod_r_reg[PROD_W-1:16];
        cg    = neg_g_reg ? -$signed(SUM_W'(q_g)) : $signed(SUM_W'(q_g));
        co    = neg_r_reg ? -$signed(SUM_W'(q_r)) : $signed(SUM_W'(q_r));
        y     = $signed(SUM_W'(pass_reg.alpha));
        sum_r = y + co - cg;
        sum_g = y + cg;
        sum_b = y - co - cg;
        conv.red   = clamp_byte(sum_r);
        conv.green = clamp_byte(sum_g);
        conv.blue  = clamp_byte(sum_b);
        conv.alpha = '1;
        out_next   = ycocg_enable ? conv : pass_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg        <= px_valid;
            out_valid_reg <= v3_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_tag_reg <= tag3_reg;
            out_px_reg  <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_px    = out_px_reg;
    assign out_tag   = out_tag_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for bc3_ycocg_block_decoder: directed and random BC3 blocks,
// each decoded in the bench into sixteen expected pixel beats for the output checker.
// Depends on design/bc3_pkg.sv and design/bc3_ycocg_block_decoder.sv.
module testbench;
    import bc3_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 24;

    // One expected pixel beat: position tag and colour.
    typedef struct packed {
        pix_tag_t tag;
        rgba_t    rgba;
    } pixel_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [BLK_W-1:0]     alpha_block;
    logic [BLK_W-1:0]     color_block;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     pixel_index;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [CH_W-1:0]      alpha;
    logic                 last_pixel;

    pixel_beat_t pending_pixels[$];
    logic        ycocg_on;
    int          mismatches;
    int          burst_left;
    int          idle_cycles;
    int          hold_seq;
    int          hold_seen;
    int          hold_left;
    int          stall_mode;
    int          mode_left;

    bc3_ycocg_block_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .alpha_block (alpha_block),
        .color_block (color_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .last_pixel  (last_pixel)
    );

    // Clock with a period of two time units.
    always #1 clk = ~clk;

    // Bit-replicating expansion of one RGB565 value to three 8-bit channels.
    function automatic void expand_rgb565(input logic [15:0] c, output int rgb[3]);
        rgb[0] = int'({c[15:11], c[15:13]});
        rgb[1] = int'({c[10:5], c[10:9]});
        rgb[2] = int'({c[4:0], c[4:2]});
    endfunction

    // Alpha for one 3-bit index, in eight-step or six-step mode.
    function automatic int alpha_step(input int e0, input int e1, input int idx);
        if (idx == 0)
            return e0;
        if (idx == 1)
            return e1;
        if (e0 > e1)
            return ((8 - idx) * e0 + (idx - 1) * e1) / 7;
        if (idx == 6)
            return 0;
        if (idx == 7)
            return 255;
        return ((6 - idx) * e0 + (idx - 1) * e1) / 5;
    endfunction

    function automatic int clamp_byte(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // Decodes one block and queues its sixteen expected pixel beats.
    function automatic void decode_bc3_block(input logic [BLK_W-1:0] ab,
                                             input logic [BLK_W-1:0] cb);
        int          p0[3];
        int          p1[3];
        int          pal[4][3];
        int          e0;
        int          e1;
        int          ci;
        int          ai;
        int          r;
        int          g;
        int          b;
        int          a;
        int          s;
        int          cg;
        int          co;
        logic        four;
        pixel_beat_t beat;

        e0 = int'(ab[7:0]);
        e1 = int'(ab[15:8]);
        four = cb[15:0] > cb[31:16];
        expand_rgb565(cb[15:0], p0);
        expand_rgb565(cb[31:16], p1);
        for (int k = 0; k < 3; k++)
        begin
            pal[0][k] = p0[k];
            pal[1][k] = p1[k];
            if (four)
            begin
                pal[2][k] = (2 * p0[k] + p1[k]) / 3;
                pal[3][k] = (2 * p1[k] + p0[k]) / 3;
            end
            else
            begin
                pal[2][k] = (p0[k] + p1[k]) / 2;
                pal[3][k] = 0;
            end
        end

        for (int p = 0; p < NUM_PIX; p++)
        begin
            ci = int'(cb[CIDX_LSB + 2 * p +: 2]);
            ai = int'(ab[AIDX_LSB + 3 * p +: 3]);
            r = pal[ci][0];
            g = pal[ci][1];
            b = pal[ci][2];
            a = alpha_step(e0, e1, ai);
            // Scaled YCoCg: alpha carries luma, blue carries the scale.
            if (ycocg_on)
            begin
                s = (b >> 3) + 1;
                cg = (g - 128) / s;
                co = (r - 128) / s;
                r = clamp_byte(a + co - cg);
                g = clamp_byte(a + cg);
                b = clamp_byte(a - co - cg);
                a = 255;
            end
            beat.tag.pix = PIX_W'(p);
            beat.tag.last = (p == NUM_PIX - 1);
            beat.rgba.red = CH_W'(r);
            beat.rgba.green = CH_W'(g);
            beat.rgba.blue = CH_W'(b);
            beat.rgba.alpha = CH_W'(a);
            pending_pixels.push_back(beat);
        end
    endfunction

    // Index field in which pixel p takes p modulo the index range.
    function automatic logic [47:0] index_ramp(input int bits);
        logic [47:0] v;
        v = '0;
        for (int p = 0; p < NUM_PIX; p++)
            v[bits * p +: 3] = 3'(p % (1 << bits));
        return v;
    endfunction

    // Sends one block beat; the sender works in bursts with random gaps.
    task automatic send_block(input logic [BLK_W-1:0] ab, input logic [BLK_W-1:0] cb);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            alpha_block <= {$urandom(), $urandom()};
            color_block <= {$urandom(), $urandom()};
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        in_valid <= 1'b1;
        alpha_block <= ab;
        color_block <= cb;
        do
            @(posedge clk);
        while (in_stall);
        decode_bc3_block(ab, cb);
    endtask

    // Lowers the block valid and waits until every pixel beat has been seen.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Writes the conversion enable once the block is idle.
    task automatic write_ycocg_enable(input logic en);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= en;
        do
            @(posedge clk);
        while (!cfg_ready);
        ycocg_on = en;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= $urandom_range(0, 1);
    endtask

    // Endpoint extremes, both colour and both alpha modes, equal endpoints and clamping.
    task automatic test_directed_blocks();
        logic [47:0] aramp;
        logic [31:0] cramp;
        aramp = index_ramp(3);
        cramp = 32'(index_ramp(2));
        send_block('0, '0);
        send_block('1, '1);
        send_block({aramp, 8'h10, 8'hF0}, {cramp, 16'h07E0, 16'hF81F});
        send_block({aramp, 8'hF0, 8'h10}, {cramp, 16'hF800, 16'h001F});
        send_block({aramp, 8'h00, 8'hFF}, {cramp, 16'h0000, 16'hFFFF});
        send_block({aramp, 8'hFF, 8'h00}, {cramp, 16'hFFFF, 16'h0000});
        send_block({aramp, 8'h80, 8'h80}, {cramp, 16'h7BEF, 16'h7BEF});
        send_block({48'h0, 8'h00, 8'h00}, {cramp, 16'h0000, 16'hF800});
        send_block({48'h0, 8'hFF, 8'hFF}, {cramp, 16'hFFFF, 16'h07E0});
        send_block({~aramp, 8'h01, 8'h02}, {~cramp, 16'h0001, 16'h0000});
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    endtask

    // The reset value of the enable converts YCoCg without any write.
    task automatic test_reset_conversion();
        test_directed_blocks();
    endtask

    // Plain colour and alpha pass through with conversion off.
    task automatic test_passthrough();
        write_ycocg_enable(1'b0);
        test_directed_blocks();
    endtask

    // Random blocks with endpoints biased towards equal and extreme cases.
    task automatic test_random_blocks(input logic en, input int count);
        logic [BLK_W-1:0] ab;
        logic [BLK_W-1:0] cb;
        logic [15:0]      tmp;
        write_ycocg_enable(en);
        for (int n = 0; n < count; n++)
        begin
            ab = {$urandom(), $urandom()};
            cb = {$urandom(), $urandom()};
            case ($urandom_range(0, 5))
                0: cb[31:16] = cb[15:0];
                1:
                begin
                    if (cb[15:0] < cb[31:16])
                    begin
                        tmp = cb[15:0];
                        cb[15:0] = cb[31:16];
                        cb[31:16] = tmp;
                    end
                end
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: ab[15:8] = ab[7:0];
                1: ab[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
                default: ;
            endcase
            send_block(ab, cb);
        end
    endtask

    // The receiver holds off for a long stretch while blocks keep coming.
    task automatic test_output_backpressure(input int count);
        wait_idle();
        @(negedge clk);
        hold_seq = hold_seq + 1;
        burst_left = count + 1;
        for (int n = 0; n < count; n++)
            send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
    endtask

    // Receiver stall: random patterns held for random stretches, plus a hold-off.
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Compares each accepted pixel beat with the oldest expectation.
    always @(posedge clk)
    begin
        pixel_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel beat with no block pending: pixel_index %0d", pixel_index);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_index !== want.tag.pix)
                begin
                    $error("pixel_index expected %0d actual %0d", want.tag.pix, pixel_index);
                    mismatches++;
                end
                if (red !== want.rgba.red)
                begin
                    $error("red expected %0d actual %0d", want.rgba.red, red);
                    mismatches++;
                end
                if (green !== want.rgba.green)
                begin
                    $error("green expected %0d actual %0d", want.rgba.green, green);
                    mismatches++;
                end
                if (blue !== want.rgba.blue)
                begin
                    $error("blue expected %0d actual %0d", want.rgba.blue, blue);
                    mismatches++;
                end
                if (alpha !== want.rgba.alpha)
                begin
                    $error("alpha expected %0d actual %0d", want.rgba.alpha, alpha);
                    mismatches++;
                end
                if (last_pixel !== want.tag.last)
                begin
                    $error("last_pixel expected %0d actual %0d", want.tag.last, last_pixel);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        alpha_block = '0;
        color_block = '0;
        out_stall = 1'b0;
        ycocg_on = 1'b1;
        mismatches = 0;
        burst_left = 0;
        idle_cycles = 0;
        hold_seq = 0;
        hold_seen = 0;
        hold_left = 0;
        stall_mode = 0;
        mode_left = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_conversion();
        test_passthrough();
        test_random_blocks(1'b1, 45);
        test_random_blocks(1'b0, 45);
        test_random_blocks(1'b1, 40);
        test_output_backpressure(20);

        // Let stray beats show up after the last expectation has been met.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
